// ===== rtl/mlr_pkg.sv =====
// shared definitions for the midpoint line rasterizer
// octant codes and command codes; no dependencies
package mlr_pkg;

  // octant of a line, named by the (major, minor) mapping from original (x, y)
  typedef enum logic [2:0] {
    OCT_XY   = 3'd0,
    OCT_YX   = 3'd1,
    OCT_YNX  = 3'd2,
    OCT_NXY  = 3'd3,
    OCT_NXNY = 3'd4,
    OCT_NYNX = 3'd5,
    OCT_NYX  = 3'd6,
    OCT_XNY  = 3'd7
  } octant_t;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

endpackage

// ===== rtl/midpoint_line_rasterizer.sv =====
// Midpoint line rasterizer for all eight octants. A start transaction (func = 0)
// sets up a line from its two endpoints and yields the first pixel; each advance
// transaction (func = 1) yields the next pixel, with last_pixel set at the far
// endpoint. An advance with no line in progress yields nothing, and a start
// abandons any line in progress. One command is taken every clock while no pixel
// waits or the waiting pixel is taken, and its pixel appears in the output register
// on the next cycle; the rate is set by the decision update (one add and one
// compare) feeding the line state registers. Commands keep flowing while a pixel
// waits, as long as the pixel is taken in the same cycle.
// depends on mlr_pkg, mlr_setup, mlr_unmap
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic                         func,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last_pixel
);

  localparam int W = COORD_BITS + 1;
  localparam int D = COORD_BITS + 3;

  // line state
  mlr_pkg::octant_t    octant_code;
  logic signed [W-1:0] pos_major, pos_minor, end_major;
  logic signed [D-1:0] decision, step_east, step_northeast;
  logic                line_active;

  mlr_pkg::octant_t    octant_code_next;
  logic signed [W-1:0] pos_major_next, pos_minor_next, end_major_next;
  logic signed [D-1:0] decision_next, step_east_next, step_northeast_next;

  // setup results
  mlr_pkg::octant_t    su_octant;
  logic signed [W-1:0] su_pos_major, su_pos_minor, su_end_major;
  logic signed [D-1:0] su_decision, su_step_east, su_step_northeast;

  logic signed [COORD_BITS-1:0] map_x, map_y;
  logic                         accept, is_start, emit, last_next;

  mlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .octant         (su_octant),
    .pos_major      (su_pos_major),
    .pos_minor      (su_pos_minor),
    .end_major      (su_end_major),
    .decision       (su_decision),
    .step_east      (su_step_east),
    .step_northeast (su_step_northeast)
  );

  assign cmd_ready = !pix_valid || pix_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign is_start  = (func == mlr_pkg::FUNC_START);
  assign emit      = is_start || line_active;

  always_comb begin
    octant_code_next    = octant_code;
    pos_major_next      = pos_major;
    pos_minor_next      = pos_minor;
    end_major_next      = end_major;
    decision_next       = decision;
    step_east_next      = step_east;
    step_northeast_next = step_northeast;
    if (is_start) begin
      octant_code_next    = su_octant;
      pos_major_next      = su_pos_major;
      pos_minor_next      = su_pos_minor;
      end_major_next      = su_end_major;
      decision_next       = su_decision;
      step_east_next      = su_step_east;
      step_northeast_next = su_step_northeast;
    end else begin
      pos_major_next = pos_major + W'(1);
      // positive decision means the northeast step
      if (decision > 0) begin
        pos_minor_next = pos_minor + W'(1);
        decision_next  = decision + step_northeast;
      end else begin
        decision_next  = decision + step_east;
      end
    end
  end

  assign last_next = (pos_major_next == end_major_next);

  mlr_unmap #(.COORD_BITS(COORD_BITS)) u_unmap (
    .octant (octant_code_next),
    .major  (pos_major_next),
    .minor  (pos_minor_next),
    .x      (map_x),
    .y      (map_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      octant_code    <= mlr_pkg::OCT_XY;
      pos_major      <= '0;
      pos_minor      <= '0;
      end_major      <= '0;
      decision       <= '0;
      step_east      <= '0;
      step_northeast <= '0;
      line_active    <= 1'b0;
    end else if (accept && emit) begin
      octant_code    <= octant_code_next;
      pos_major      <= pos_major_next;
      pos_minor      <= pos_minor_next;
      end_major      <= end_major_next;
      decision       <= decision_next;
      step_east      <= step_east_next;
      step_northeast <= step_northeast_next;
      line_active    <= !last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (accept && emit) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      pixel_x    <= map_x;
      pixel_y    <= map_y;
      last_pixel <= last_next;
    end
  end

endmodule

// ===== rtl/mlr_setup.sv =====
// line setup: octant selection, first-octant endpoints and decision terms
// depends on mlr_pkg
module mlr_setup #(
  parameter int COORD_BITS = 11
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output mlr_pkg::octant_t             octant,
  output logic signed [COORD_BITS:0]   pos_major,
  output logic signed [COORD_BITS:0]   pos_minor,
  output logic signed [COORD_BITS:0]   end_major,
  output logic signed [COORD_BITS+2:0] decision,
  output logic signed [COORD_BITS+2:0] step_east,
  output logic signed [COORD_BITS+2:0] step_northeast
);

  localparam int W = COORD_BITS + 1;

  function automatic logic signed [W-1:0] to_major(mlr_pkg::octant_t oc,
                                                   logic signed [W-1:0] x,
                                                   logic signed [W-1:0] y);
    logic signed [W-1:0] r;
    case (oc)
      mlr_pkg::OCT_XY:   r = x;
      mlr_pkg::OCT_YX:   r = y;
      mlr_pkg::OCT_YNX:  r = y;
      mlr_pkg::OCT_NXY:  r = -x;
      mlr_pkg::OCT_NXNY: r = -x;
      mlr_pkg::OCT_NYNX: r = -y;
      mlr_pkg::OCT_NYX:  r = -y;
      mlr_pkg::OCT_XNY:  r = x;
      default:           r = x;
    endcase
    return r;
  endfunction

  function automatic logic signed [W-1:0] to_minor(mlr_pkg::octant_t oc,
                                                   logic signed [W-1:0] x,
                                                   logic signed [W-1:0] y);
    logic signed [W-1:0] r;
    case (oc)
      mlr_pkg::OCT_XY:   r = y;
      mlr_pkg::OCT_YX:   r = x;
      mlr_pkg::OCT_YNX:  r = -x;
      mlr_pkg::OCT_NXY:  r = y;
      mlr_pkg::OCT_NXNY: r = -y;
      mlr_pkg::OCT_NYNX: r = -x;
      mlr_pkg::OCT_NYX:  r = x;
      mlr_pkg::OCT_XNY:  r = -y;
      default:           r = y;
    endcase
    return r;
  endfunction

  logic signed [W-1:0] x0, y0, x1, y1;
  logic signed [W-1:0] dx, dy;
  logic        [W-1:0] ax, ay;
  logic        [W-1:0] dmaj, dmin;
  logic                x_major;

  assign x0 = W'(start_x);
  assign y0 = W'(start_y);
  assign x1 = W'(end_x);
  assign y1 = W'(end_y);

  assign dx = x1 - x0;
  assign dy = y1 - y0;
  assign ax = dx[W-1] ? W'(-dx) : W'(dx);
  assign ay = dy[W-1] ? W'(-dy) : W'(dy);
  assign x_major = (ax >= ay);

  always_comb begin
    case ({dx[W-1], dy[W-1]})
      2'b00:   octant = x_major ? mlr_pkg::OCT_XY   : mlr_pkg::OCT_YX;
      2'b10:   octant = x_major ? mlr_pkg::OCT_NXY  : mlr_pkg::OCT_YNX;
      2'b11:   octant = x_major ? mlr_pkg::OCT_NXNY : mlr_pkg::OCT_NYNX;
      default: octant = x_major ? mlr_pkg::OCT_XNY  : mlr_pkg::OCT_NYX;
    endcase
  end

  assign pos_major = to_major(octant, x0, y0);
  assign pos_minor = to_minor(octant, x0, y0);
  assign end_major = to_major(octant, x1, y1);

  // in the first octant the deltas are just the larger and smaller magnitudes
  assign dmaj = x_major ? ax : ay;
  assign dmin = x_major ? ay : ax;

  assign step_east      = $signed({1'b0, dmin, 1'b0});
  assign decision       = $signed({1'b0, dmin, 1'b0}) - $signed({2'b00, dmaj});
  assign step_northeast = $signed({1'b0, dmin, 1'b0}) - $signed({1'b0, dmaj, 1'b0});

endmodule

// ===== rtl/mlr_unmap.sv =====
// maps a first-octant position back to the original frame
// depends on mlr_pkg
module mlr_unmap #(
  parameter int COORD_BITS = 11
) (
  input  mlr_pkg::octant_t             octant,
  input  logic signed [COORD_BITS:0]   major,
  input  logic signed [COORD_BITS:0]   minor,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y
);

  localparam int W = COORD_BITS + 1;

  logic signed [W-1:0] xf, yf;

  always_comb begin
    case (octant)
      mlr_pkg::OCT_XY:   begin xf = major;  yf = minor;  end
      mlr_pkg::OCT_YX:   begin xf = minor;  yf = major;  end
      mlr_pkg::OCT_YNX:  begin xf = -minor; yf = major;  end
      mlr_pkg::OCT_NXY:  begin xf = -major; yf = minor;  end
      mlr_pkg::OCT_NXNY: begin xf = -major; yf = -minor; end
      mlr_pkg::OCT_NYNX: begin xf = -minor; yf = -major; end
      mlr_pkg::OCT_NYX:  begin xf = minor;  yf = -major; end
      mlr_pkg::OCT_XNY:  begin xf = major;  yf = -minor; end
      default:           begin xf = major;  yf = minor;  end
    endcase
  end

  assign x = xf[COORD_BITS-1:0];
  assign y = yf[COORD_BITS-1:0];

endmodule
